// ===== design/lass_pkg.sv =====
// ----------------------------------------------------------------------------
// lass_pkg
// Types, register indexes and the B3/S23 rule shared by the life step unit.
// ----------------------------------------------------------------------------
package lass_pkg;

  localparam int unsigned CFG_W     = 11;  // configuration register width
  localparam int unsigned CFG_IDX_W = 1;   // register index width
  localparam int unsigned COORD_W   = 10;  // emitted coordinate width
  localparam int unsigned WIN_W     = 9;   // 3x3 window, bit = col*3 + row

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

  // Input request: raster cell or padding tick
  typedef struct packed {
    logic req_type;    // 0 frame cell, 1 padding tick
    logic live;
  } in_req_t;

  typedef struct packed {
    logic               next_alive;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               frame_done;
    logic               last_in_run;
  } out_res_t;

  // Birth on exactly three live neighbours, survival on two or three.
  function automatic logic rule_next(input logic [WIN_W-1:0] win);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < WIN_W; i++) begin
      if (i != 4) n = n + {3'b000, win[i]};
    end
    return (n == 4'd3) || (win[4] && (n == 4'd2));
  endfunction

endpackage

// ===== design/life_automaton_stream_step_unit.sv =====
// ----------------------------------------------------------------------------
// life_automaton_stream_step_unit
// One generation of the B3/S23 life automaton over a raster stream of cells,
// bounded grid, with two line stores and a 3x3 neighbour window.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload   | handshake
//  --------+-----+-----------+----------------------------------------------
//  in_     | in  | in_req_t  | in_valid / in_stall, taken when !in_stall
//  out_    | out | out_res_t | out_valid / out_stall, taken when !out_stall
//  cfg_    | in  | 11 bits   | cfg_we, cfg_index, cfg_wdata, no wait
//
//  One request per cycle sustained while out_stall is low; a row-end request
//  gives two results and, with a single output port, holds the input while
//  the second waits in the pending slot. The line store read issues as the
//  request is taken, into the stage 1 registers; the result register loads
//  when stage 1 fires, so a result passes both before it shows on out_.
//  Reset clears counters, window, valids and sets both dimensions to 1024;
//  the line stores are not cleared (reads of unwritten entries are masked).
//  An output stall backs up through the result register into the window
//  stage; the line store read data holds while that stage waits.
//
module life_automaton_stream_step_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lass_pkg::in_req_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lass_pkg::out_res_t                out_data,
  input  logic                              cfg_we,
  input  logic [lass_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lass_pkg::CFG_W-1:0]        cfg_wdata
);
  import lass_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);        // column / address
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);    // width in use
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);   // row count
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);   // height in use

  // -- configuration ---------------------------------------------------------
  logic [CFG_W-1:0] frame_width_r, frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= DIM_RESET;
      frame_height_r <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp to [3, MAX]
  logic [WW-1:0] w_use;
  logic [HW-1:0] h_use;
  assign w_use = (frame_width_r < CFG_W'(3)) ? WW'(3) :
                 (32'(frame_width_r) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(frame_width_r);
  assign h_use = (frame_height_r < CFG_W'(3)) ? HW'(3) :
                 (32'(frame_height_r) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(frame_height_r);

  // -- stage 0: raster counters, line store read issue ----------------------
  logic [CW-1:0] col_cnt_r;
  logic [RW-1:0] row_cnt_r;
  logic          in_accept;
  logic          row_end, pad_row;

  assign row_end = (32'(col_cnt_r) + 32'd1) >= 32'(w_use);
  assign pad_row = 32'(row_cnt_r) >= 32'(h_use);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_accept) begin
      if (row_end) begin
        col_cnt_r <= '0;
        row_cnt_r <= pad_row ? '0 : RW'(row_cnt_r + 1'b1);
      end else begin
        col_cnt_r <= CW'(col_cnt_r + 1'b1);
      end
    end
  end

  // -- line stores: one bit per column each, registered read -----------------
  logic row_above_mem     [MAX_WIDTH];
  logic row_two_above_mem [MAX_WIDTH];
  logic above_q, two_above_q;

  // stage 1 request
  logic          s1_valid_r;
  logic          s1_fire;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  logic          s1_cur_r;
  logic          s1_col_zero_r, s1_row_ge1_r, s1_row_ge2_r;
  logic          s1_row_end_r, s1_pad_row_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      above_q     <= row_above_mem[col_cnt_r];
      two_above_q <= row_two_above_mem[col_cnt_r];
    end
    // write-back a row ahead of the next read of this column
    if (s1_fire) begin
      row_above_mem[s1_col_r]     <= s1_cur_r;
      row_two_above_mem[s1_col_r] <= s1_row_ge1_r & above_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col_r      <= col_cnt_r;
      s1_row_r      <= row_cnt_r;
      // padding tick or any cell in the padding row reads as dead
      s1_cur_r      <= !pad_row && !in_data.req_type && in_data.live;
      s1_col_zero_r <= (col_cnt_r == '0);
      s1_row_ge1_r  <= (row_cnt_r != '0);
      s1_row_ge2_r  <= (32'(row_cnt_r) >= 32'd2);
      s1_row_end_r  <= row_end;
      s1_pad_row_r  <= pad_row;
    end
  end

  // -- stage 1: window shift, rule, result build ----------------------------
  logic [WIN_W-1:0] win_r, win_base, win;
  logic             a_bit, b_bit;

  assign a_bit    = s1_row_ge2_r & two_above_q;   // rows above frame are dead
  assign b_bit    = s1_row_ge1_r & above_q;
  assign win_base = s1_col_zero_r ? '0 : win_r;   // dead column left of frame
  assign win      = {s1_cur_r, b_bit, a_bit, win_base[WIN_W-1:3]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_fire) begin
      win_r <= win;
    end
  end

  logic     res0_v, res1_v;
  out_res_t res0, res1;

  assign res0_v = s1_row_ge1_r && !s1_col_zero_r;
  assign res1_v = s1_row_ge1_r && s1_row_end_r;

  always_comb begin
    res0.next_alive  = rule_next(win);
    res0.cell_x      = COORD_W'(32'(s1_col_r) - 32'd1);
    res0.cell_y      = COORD_W'(32'(s1_row_r) - 32'd1);
    res0.frame_done  = 1'b0;
    res0.last_in_run = !s1_row_end_r;
    // right of the last column is dead
    res1.next_alive  = rule_next({3'b000, win[WIN_W-1:3]});
    res1.cell_x      = COORD_W'(s1_col_r);
    res1.cell_y      = COORD_W'(32'(s1_row_r) - 32'd1);
    res1.frame_done  = s1_pad_row_r;
    res1.last_in_run = 1'b1;
  end

  // -- result register plus one pending slot for the row-end second result --
  logic     out_valid_r, pend_valid_r, out_take;
  out_res_t out_data_r, pend_data_r;

  assign out_take  = out_valid_r && !out_stall;
  assign s1_fire   = s1_valid_r && !pend_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (pend_valid_r && out_take) begin
      out_valid_r  <= 1'b1;
      pend_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r  <= res0_v || res1_v;
      pend_valid_r <= res0_v && res1_v;
    end else if (out_take) begin
      out_valid_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid_r && out_take) begin
      out_data_r <= pend_data_r;
    end else if (s1_fire) begin
      out_data_r  <= res0_v ? res0 : res1;
      pend_data_r <= res1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // -- checks ----------------------------------------------------------------
  a_pend_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("pending result without a result in the output register");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && s1_fire) |-> (col_cnt_r != s1_col_r))
    else $error("line store read and write-back hit the same column");

  a_row_end_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res0_v && res1_v) |=> (pend_valid_r && out_valid_r))
    else $error("row-end second result lost");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.frame_done) |-> out_data_r.last_in_run)
    else $error("frame_done on a result that is not last of its request");

  a_no_accept_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && pend_valid_r) |-> !in_accept)
    else $error("request taken while window stage blocked");

endmodule
